>>> hdl/keyframe_eased_interpolator_assert.svh
// Assertion macros for the keyframe eased interpolator checker.
`ifndef KEYFRAME_EASED_INTERPOLATOR_ASSERT_SVH
`define KEYFRAME_EASED_INTERPOLATOR_ASSERT_SVH

// Check a property, skipped while reset is asserted.
`define KEI_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define KEI_ASSERT_ANY(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/kei_pkg.sv
// ---------------------------------------------------------------------------
// kei_pkg
// Shared constants, types and the cosine kernel of the eased interpolator.
// ---------------------------------------------------------------------------
`default_nettype none

package kei_pkg;

  localparam int unsigned POS_FRAC_BITS     = 8;
  localparam int unsigned COS_TABLE_ENTRIES = 256;
  localparam int unsigned POS_W             = 24;
  localparam int unsigned KEY_W             = 16;
  localparam int unsigned COORD_W           = 16;
  localparam int unsigned FRAC_W            = 17;
  localparam int unsigned CFG_IDX_W         = 3;
  localparam int unsigned CFG_DATA_W        = 16;
  localparam int unsigned Q_BITS            = 16;
  localparam int unsigned DIV_STEP          = 2;
  localparam logic [FRAC_W-1:0] ONE_Q16     = 17'd65536;
  localparam longint HALF_PI_Q30            = 64'sd1686629713;
  localparam longint ONE_Q30                = 64'sd1073741824;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPAN_BEGIN = 3'd0,
    CFG_SPAN_END   = 3'd1,
    CFG_CURVE_MODE = 3'd2,
    CFG_START_X    = 3'd3,
    CFG_START_Y    = 3'd4,
    CFG_FINISH_X   = 3'd5,
    CFG_FINISH_Y   = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CURVE_LINEAR   = 2'd0,
    CURVE_IN_OUT   = 2'd1,
    CURVE_EASE_IN  = 2'd2,
    CURVE_EASE_OUT = 2'd3
  } curve_e;

  typedef struct packed {
    logic [FRAC_W-1:0] frac;
    logic              shape;
  } frac_t;

  // Truncate toward zero after a 30 bit product.
  function automatic longint shr30_tz(longint t);
    shr30_tz = (t >= 0) ? (t >>> 30) : -((-t) >>> 30);
  endfunction

  // Cosine of x (Q30, 0..pi/2) in Q16, rounded, by a Taylor series.
  function automatic logic [FRAC_W-1:0] cos_entry(longint x);
    longint x2;
    longint r;
    x2 = (x * x) >>> 30;
    r  = ONE_Q30;
    r  = ONE_Q30 - shr30_tz(x2 * r) / 240;
    r  = ONE_Q30 - shr30_tz(x2 * r) / 182;
    r  = ONE_Q30 - shr30_tz(x2 * r) / 132;
    r  = ONE_Q30 - shr30_tz(x2 * r) / 90;
    r  = ONE_Q30 - shr30_tz(x2 * r) / 56;
    r  = ONE_Q30 - shr30_tz(x2 * r) / 30;
    r  = ONE_Q30 - shr30_tz(x2 * r) / 12;
    r  = ONE_Q30 - shr30_tz(x2 * r) / 2;
    if (r < 0) begin
      r = 0;
    end
    r = (r + 64'sd8192) >>> 14;
    if (r > 64'sd65536) begin
      r = 64'sd65536;
    end
    cos_entry = FRAC_W'(r);
  endfunction

endpackage

`default_nettype wire

>>> hdl/kei_in_if.sv
// ---------------------------------------------------------------------------
// kei_in_if
// Request channel carrying one timeline position.
// ---------------------------------------------------------------------------
`default_nettype none

interface kei_in_if;
  logic                         valid;
  logic                         ready;
  logic [kei_pkg::POS_W-1:0]    timeline_pos;

  modport source (output valid, output timeline_pos, input ready);
  modport sink   (input valid, input timeline_pos, output ready);
endinterface

`default_nettype wire

>>> hdl/kei_out_if.sv
// ---------------------------------------------------------------------------
// kei_out_if
// Result channel carrying the eased fraction and the blended point.
// ---------------------------------------------------------------------------
`default_nettype none

interface kei_out_if;
  logic                                valid;
  logic                                ready;
  logic        [kei_pkg::FRAC_W-1:0]   eased_fraction;
  logic signed [kei_pkg::COORD_W-1:0]  blend_x;
  logic signed [kei_pkg::COORD_W-1:0]  blend_y;

  modport source (output valid, output eased_fraction, output blend_x, output blend_y,
                  input ready);
  modport sink   (input valid, input eased_fraction, input blend_x, input blend_y,
                  output ready);
endinterface

`default_nettype wire

>>> hdl/kei_divider.sv
// ---------------------------------------------------------------------------
// kei_divider
// Span classification and pipelined restoring division for the linear fraction.
// ---------------------------------------------------------------------------
`default_nettype none

module kei_divider #(
  parameter int unsigned PosFracBits = kei_pkg::POS_FRAC_BITS
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        en_i,
  input  wire logic                        vld_i,
  input  wire logic [kei_pkg::POS_W-1:0]   pos_i,
  input  wire logic [kei_pkg::KEY_W-1:0]   span_begin_i,
  input  wire logic [kei_pkg::KEY_W-1:0]   span_end_i,
  output logic                             vld_o,
  output kei_pkg::frac_t                   frac_o
);

  localparam int unsigned DW  = kei_pkg::KEY_W + PosFracBits;
  localparam int unsigned RW  = DW + 1;
  localparam int unsigned NST = kei_pkg::Q_BITS / kei_pkg::DIV_STEP;
  localparam int unsigned IPW = kei_pkg::POS_W + 1;
  localparam int unsigned QW  = kei_pkg::Q_BITS;
  localparam int unsigned FW  = kei_pkg::FRAC_W;

  logic          vld_q [NST+1];
  logic [RW-1:0] r_q   [NST+1];
  logic [RW-1:0] r_d   [NST+1];
  logic [QW-1:0] q_q   [NST+1];
  logic [QW-1:0] q_d   [NST+1];
  logic [DW-1:0] den_q [NST+1];
  logic [DW-1:0] den_d [NST+1];
  logic [FW-1:0] fix_q [NST+1];
  logic [FW-1:0] fix_d [NST+1];
  logic          div_q [NST+1];
  logic          div_d [NST+1];
  logic          shp_q [NST+1];
  logic          shp_d [NST+1];

  // Entry: classify the position against the span.
  always_comb begin
    logic [IPW-1:0] ip;
    logic [IPW-1:0] kb;
    logic [IPW-1:0] ke;
    logic [RW-1:0]  a;
    logic [DW-1:0]  den;
    logic           below;
    logic           past;
    ip    = IPW'(pos_i >> PosFracBits);
    kb    = IPW'(span_begin_i);
    ke    = IPW'(span_end_i);
    a     = RW'(pos_i) - (RW'(span_begin_i) << PosFracBits);
    den   = DW'(span_end_i - span_begin_i) << PosFracBits;
    below = (ip < kb) || (span_end_i == span_begin_i);
    past  = !below && (ip > ke);
    r_d[0]   = a;
    q_d[0]   = '0;
    den_d[0] = den;
    fix_d[0] = below ? '0 : kei_pkg::ONE_Q16;
    shp_d[0] = !below && !past;
    // a past den means a fraction above one: clamp
    div_d[0] = !below && !past && (a < RW'(den));
  end

  for (genvar s = 1; s <= NST; s++) begin : g_stage
    always_comb begin
      logic [RW-1:0] r;
      logic [QW-1:0] q;
      r = r_q[s-1];
      q = q_q[s-1];
      for (int k = 0; k < kei_pkg::DIV_STEP; k++) begin
        r = r << 1;
        if (r >= RW'(den_q[s-1])) begin
          r = r - RW'(den_q[s-1]);
          q = {q[QW-2:0], 1'b1};
        end else begin
          q = {q[QW-2:0], 1'b0};
        end
      end
      r_d[s]   = r;
      q_d[s]   = q;
      den_d[s] = den_q[s-1];
      fix_d[s] = fix_q[s-1];
      div_d[s] = div_q[s-1];
      shp_d[s] = shp_q[s-1];
    end
  end

  for (genvar s = 0; s <= NST; s++) begin : g_reg
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= (s == 0) ? vld_i : vld_q[(s == 0) ? 0 : s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[s]   <= r_d[s];
        q_q[s]   <= q_d[s];
        den_q[s] <= den_d[s];
        fix_q[s] <= fix_d[s];
        div_q[s] <= div_d[s];
        shp_q[s] <= shp_d[s];
      end
    end
  end

  assign vld_o        = vld_q[NST];
  assign frac_o.frac  = div_q[NST] ? FW'(q_q[NST]) : fix_q[NST];
  assign frac_o.shape = shp_q[NST];

endmodule

`default_nettype wire

>>> hdl/kei_shaper.sv
// ---------------------------------------------------------------------------
// kei_shaper
// Curve shaping of the linear fraction through a quarter-wave cosine table.
// ---------------------------------------------------------------------------
`default_nettype none

module kei_shaper #(
  parameter int unsigned CosN = kei_pkg::COS_TABLE_ENTRIES
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            vld_i,
  input  wire kei_pkg::frac_t  frac_i,
  input  wire logic [1:0]      curve_mode_i,
  output logic                 vld_o,
  output logic [kei_pkg::FRAC_W-1:0] frac_o
);

  localparam int unsigned FW = kei_pkg::FRAC_W;
  localparam int unsigned IW = $clog2(CosN + 1);
  localparam int unsigned PW = FW + IW;

  typedef logic [FW-1:0] cos_tab_t [CosN+1];

  function automatic cos_tab_t build_tab();
    cos_tab_t t;
    longint   x;
    for (int k = 0; k <= CosN; k++) begin
      x    = (kei_pkg::HALF_PI_Q30 * longint'(k) + longint'(CosN / 2)) / CosN;
      t[k] = kei_pkg::cos_entry(x);
    end
    build_tab = t;
  endfunction

  localparam cos_tab_t COS_TAB = build_tab();

  logic [2:0]    vld_q;
  logic [FW-1:0] fa_q, fb_q;
  logic          sa_q, sb_q, na_q, nb_q;
  logic [IW-1:0] idx_q;
  logic [FW-1:0] cos_q;
  logic [FW-1:0] f_q;
  logic [FW-1:0] f_d;
  logic [IW-1:0] idx_d;
  logic          neg_d;

  // Stage A: angle, fold into the first quadrant, table index.
  always_comb begin
    logic [FW:0]   h;
    logic [FW-1:0] u;
    logic [PW-1:0] p;
    case (kei_pkg::curve_e'(curve_mode_i))
      kei_pkg::CURVE_IN_OUT:   h = {frac_i.frac, 1'b0};
      kei_pkg::CURVE_EASE_OUT: h = (FW+1)'(frac_i.frac) + (FW+1)'(kei_pkg::ONE_Q16);
      default:                 h = (FW+1)'(frac_i.frac);
    endcase
    neg_d = h > (FW+1)'(kei_pkg::ONE_Q16);
    u     = neg_d ? FW'((FW+1)'(18'd131072) - h) : FW'(h);
    p     = PW'(u) * PW'(CosN) + PW'(32768);
    idx_d = IW'(p >> 16);
  end

  // Stage C: apply the curve.
  always_comb begin
    logic [FW:0] t;
    f_d = fb_q;
    t   = '0;
    if (sb_q) begin
      case (kei_pkg::curve_e'(curve_mode_i))
        kei_pkg::CURVE_IN_OUT: begin
          t   = nb_q ? (FW+1)'(kei_pkg::ONE_Q16) + (FW+1)'(cos_q)
                     : (FW+1)'(kei_pkg::ONE_Q16) - (FW+1)'(cos_q);
          f_d = FW'(t >> 1);
        end
        kei_pkg::CURVE_EASE_IN: begin
          f_d = nb_q ? kei_pkg::ONE_Q16 + cos_q : kei_pkg::ONE_Q16 - cos_q;
        end
        kei_pkg::CURVE_EASE_OUT: begin
          f_d = nb_q ? cos_q : FW'(0) - cos_q;
        end
        default: f_d = fb_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fa_q  <= frac_i.frac;
      sa_q  <= frac_i.shape;
      na_q  <= neg_d;
      idx_q <= idx_d;
      fb_q  <= fa_q;
      sb_q  <= sa_q;
      nb_q  <= na_q;
      cos_q <= COS_TAB[idx_q];
      f_q   <= f_d;
    end
  end

  assign vld_o  = vld_q[2];
  assign frac_o = f_q;

endmodule

`default_nettype wire

>>> hdl/kei_blend.sv
// ---------------------------------------------------------------------------
// kei_blend
// Linear blend of both coordinates by the eased fraction, toward-zero rounding.
// ---------------------------------------------------------------------------
`default_nettype none

module kei_blend (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               en_i,
  input  wire logic                               vld_i,
  input  wire logic        [kei_pkg::FRAC_W-1:0]  frac_i,
  input  wire logic signed [kei_pkg::COORD_W-1:0] start_x_i,
  input  wire logic signed [kei_pkg::COORD_W-1:0] start_y_i,
  input  wire logic signed [kei_pkg::COORD_W-1:0] finish_x_i,
  input  wire logic signed [kei_pkg::COORD_W-1:0] finish_y_i,
  output logic                                    vld_o,
  output logic             [kei_pkg::FRAC_W-1:0]  frac_o,
  output logic signed      [kei_pkg::COORD_W-1:0] x_o,
  output logic signed      [kei_pkg::COORD_W-1:0] y_o
);

  localparam int unsigned CW = kei_pkg::COORD_W;
  localparam int unsigned FW = kei_pkg::FRAC_W;
  localparam int unsigned MW = CW + 1 + FW + 1;
  localparam int unsigned SW = MW + 1;

  logic [1:0]           vld_q;
  logic [FW-1:0]        fm_q, fo_q;
  logic signed [MW-1:0] px_q, py_q, px_d, py_d;
  logic signed [CW-1:0] sx_q, sy_q;
  logic signed [CW-1:0] x_q, y_q, x_d, y_d;

  function automatic logic signed [CW-1:0] trunc16(logic signed [SW-1:0] s);
    logic signed [SW-1:0] t;
    t       = (s < 0) ? s + SW'(65535) : s;
    trunc16 = CW'(t >>> 16);
  endfunction

  // start*(1-f) + finish*f = start + (finish-start)*f
  always_comb begin
    logic signed [CW:0] dx;
    logic signed [CW:0] dy;
    logic signed [FW:0] fs;
    dx   = (CW+1)'(finish_x_i) - (CW+1)'(start_x_i);
    dy   = (CW+1)'(finish_y_i) - (CW+1)'(start_y_i);
    fs   = $signed({1'b0, frac_i});
    px_d = MW'(dx) * MW'(fs);
    py_d = MW'(dy) * MW'(fs);
  end

  always_comb begin
    x_d = trunc16((SW'(sx_q) <<< 16) + SW'(px_q));
    y_d = trunc16((SW'(sy_q) <<< 16) + SW'(py_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_q <= px_d;
      py_q <= py_d;
      sx_q <= start_x_i;
      sy_q <= start_y_i;
      fm_q <= frac_i;
      x_q  <= x_d;
      y_q  <= y_d;
      fo_q <= fm_q;
    end
  end

  assign vld_o  = vld_q[1];
  assign frac_o = fo_q;
  assign x_o    = x_q;
  assign y_o    = y_q;

endmodule

`default_nettype wire

>>> hdl/keyframe_eased_interpolator.sv
// ---------------------------------------------------------------------------
// keyframe_eased_interpolator
// Eased keyframe span evaluation: fraction, curve shaping and 2-D blend.
// ---------------------------------------------------------------------------
// Channel  Dir  Handshake      Payload
// in_i     in   valid/ready    timeline_pos (24b, Q16.8)
// out_o    out  valid/ready    eased_fraction (17b), blend_x, blend_y (16b signed)
// cfg      in   cfg_we_i       cfg_idx_i (3b), cfg_data_i (16b)
//
// One request per cycle unless the result stalls; stages: entry stage, eight divider stages
// (two quotient bits each), three shaping stages, two blend stages.
// The whole pipeline advances together; a stalled result holds every stage.
// Reset clears the valid bits and the config registers only; no clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none

module keyframe_eased_interpolator #(
  parameter int unsigned POS_FRAC_BITS     = kei_pkg::POS_FRAC_BITS,
  parameter int unsigned COS_TABLE_ENTRIES = kei_pkg::COS_TABLE_ENTRIES
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  kei_in_if.sink                                 in_i,
  kei_out_if.source                              out_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [kei_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [kei_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned CW = kei_pkg::COORD_W;
  localparam int unsigned KW = kei_pkg::KEY_W;
  localparam int unsigned FW = kei_pkg::FRAC_W;

  logic [KW-1:0]        span_begin_q, span_end_q;
  logic [1:0]           curve_mode_q;
  logic signed [CW-1:0] start_x_q, start_y_q, finish_x_q, finish_y_q;

  logic           en;
  logic           div_vld, shp_vld, out_vld;
  kei_pkg::frac_t div_frac;
  logic [FW-1:0]  shp_frac;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      span_begin_q <= '0;
      span_end_q   <= '0;
      curve_mode_q <= '0;
      start_x_q    <= '0;
      start_y_q    <= '0;
      finish_x_q   <= '0;
      finish_y_q   <= '0;
    end else if (cfg_we_i) begin
      case (kei_pkg::cfg_idx_e'(cfg_idx_i))
        kei_pkg::CFG_SPAN_BEGIN: span_begin_q <= cfg_data_i;
        kei_pkg::CFG_SPAN_END:   span_end_q   <= cfg_data_i;
        kei_pkg::CFG_CURVE_MODE: curve_mode_q <= cfg_data_i[1:0];
        kei_pkg::CFG_START_X:    start_x_q    <= cfg_data_i;
        kei_pkg::CFG_START_Y:    start_y_q    <= cfg_data_i;
        kei_pkg::CFG_FINISH_X:   finish_x_q   <= cfg_data_i;
        kei_pkg::CFG_FINISH_Y:   finish_y_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Advance the pipeline unless the result register is full and stalled.
  assign en         = !out_vld || out_o.ready;
  assign in_i.ready = en;

  kei_divider #(
    .PosFracBits (POS_FRAC_BITS)
  ) u_div (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .vld_i        (in_i.valid),
    .pos_i        (in_i.timeline_pos),
    .span_begin_i (span_begin_q),
    .span_end_i   (span_end_q),
    .vld_o        (div_vld),
    .frac_o       (div_frac)
  );

  kei_shaper #(
    .CosN (COS_TABLE_ENTRIES)
  ) u_shp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .vld_i        (div_vld),
    .frac_i       (div_frac),
    .curve_mode_i (curve_mode_q),
    .vld_o        (shp_vld),
    .frac_o       (shp_frac)
  );

  kei_blend u_bld (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .vld_i      (shp_vld),
    .frac_i     (shp_frac),
    .start_x_i  (start_x_q),
    .start_y_i  (start_y_q),
    .finish_x_i (finish_x_q),
    .finish_y_i (finish_y_q),
    .vld_o      (out_vld),
    .frac_o     (out_o.eased_fraction),
    .x_o        (out_o.blend_x),
    .y_o        (out_o.blend_y)
  );

  assign out_o.valid = out_vld;

endmodule

`default_nettype wire

>>> hdl/kei_checker.sv
// ---------------------------------------------------------------------------
// kei_checker
// Port-level checks of the eased interpolator, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
`include "keyframe_eased_interpolator_assert.svh"

module kei_checker (
  input wire logic                               clk_i,
  input wire logic                               rst_ni,
  input wire logic                               in_valid_i,
  input wire logic                               in_ready_i,
  input wire logic                               out_valid_i,
  input wire logic                               out_ready_i,
  input wire logic        [kei_pkg::FRAC_W-1:0]  frac_i,
  input wire logic signed [kei_pkg::COORD_W-1:0] x_i,
  input wire logic signed [kei_pkg::COORD_W-1:0] y_i,
  input wire logic                               cfg_we_i,
  input wire logic [kei_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input wire logic [kei_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  logic [kei_pkg::COORD_W-1:0] sx_q, sy_q, fx_q, fy_q;

  // Track the endpoints from the write port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sx_q <= '0;
      sy_q <= '0;
      fx_q <= '0;
      fy_q <= '0;
    end else if (cfg_we_i) begin
      case (kei_pkg::cfg_idx_e'(cfg_idx_i))
        kei_pkg::CFG_START_X:  sx_q <= cfg_data_i;
        kei_pkg::CFG_START_Y:  sy_q <= cfg_data_i;
        kei_pkg::CFG_FINISH_X: fx_q <= cfg_data_i;
        kei_pkg::CFG_FINISH_Y: fy_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  `KEI_ASSERT_ANY(a_ready_follows_out, clk_i, in_ready_i == (!out_valid_i || out_ready_i), "input ready must track the result stall")
  `KEI_ASSERT_RST(a_frac_range, clk_i, rst_ni, out_valid_i |-> frac_i <= kei_pkg::ONE_Q16, "eased fraction above one")
  `KEI_ASSERT_RST(a_zero_is_start, clk_i, rst_ni, (out_valid_i && frac_i == '0) |-> (x_i == sx_q && y_i == sy_q), "zero fraction must give the start point")
  `KEI_ASSERT_RST(a_one_is_finish, clk_i, rst_ni, (out_valid_i && frac_i == kei_pkg::ONE_Q16) |-> (x_i == fx_q && y_i == fy_q), "unit fraction must give the finish point")
  `KEI_ASSERT_RST(a_stall_holds, clk_i, rst_ni, (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(frac_i) && $stable(x_i) && $stable(y_i)), "stalled result changed")

  logic unused_in_valid;
  assign unused_in_valid = in_valid_i;

endmodule

bind keyframe_eased_interpolator kei_checker u_kei_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .frac_i      (out_o.eased_fraction),
  .x_i         (out_o.blend_x),
  .y_i         (out_o.blend_y),
  .cfg_we_i    (cfg_we_i),
  .cfg_idx_i   (cfg_idx_i),
  .cfg_data_i  (cfg_data_i)
);

`default_nettype wire

>>> verif/keyframe_eased_interpolator_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// keyframe_eased_interpolator_checker
// Watches the position and result channels, computes the eased fraction and
// blended point for each accepted request and compares them in order.
// ---------------------------------------------------------------------------
`default_nettype none

module keyframe_eased_interpolator_checker (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  kei_in_if                                    pos_ch,
  kei_out_if                                   res_ch,
  input  wire logic                            cfg_we_i,
  input  wire logic [kei_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [kei_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output int                                   fail_count_o,
  output int                                   pending_o
);

  typedef struct packed {
    logic [kei_pkg::FRAC_W-1:0]         frac;
    logic signed [kei_pkg::COORD_W-1:0] x;
    logic signed [kei_pkg::COORD_W-1:0] y;
  } point_t;

  localparam int unsigned NCOS = 256;
  localparam longint HALF_PI   = 64'sd1686629713;
  localparam longint UNIT_Q30  = 64'sd1073741824;

  logic [15:0]         key_lo, key_hi;
  kei_pkg::curve_e     curve;
  logic signed [15:0]  sx, sy, ex, ey;
  longint              cos_lut [NCOS+1];
  point_t              expected_points[$];

  // Taylor series for cos, Q30 in, Q16 out.
  function automatic longint cos_q16(longint ang);
    longint sq, acc, t;
    sq  = (ang * ang) >>> 30;
    acc = UNIT_Q30;
    for (int n = 16; n >= 2; n -= 2) begin
      t   = sq * acc;
      t   = (t >= 0) ? (t >>> 30) : -((-t) >>> 30);
      acc = UNIT_Q30 - t / (n * (n - 1));
    end
    if (acc < 0) acc = 0;
    acc = (acc + 8192) >>> 14;
    return (acc > 65536) ? 65536 : acc;
  endfunction

  function automatic longint signed_cos(longint h);
    longint u, k;
    if (h > 131072) h = 131072;
    u = (h <= 65536) ? h : 131072 - h;
    k = (u * NCOS + 32768) >>> 16;
    if (k > NCOS) k = NCOS;
    return (h > 65536) ? -cos_lut[k] : cos_lut[k];
  endfunction

  function automatic longint mix(longint a, longint b, longint f);
    return (a * (65536 - f) + b * f) / 65536;
  endfunction

  function automatic point_t eval_position(logic [kei_pkg::POS_W-1:0] pos);
    longint ip, f, num, den;
    point_t p;
    ip = pos >> kei_pkg::POS_FRAC_BITS;
    if (ip < key_lo || key_hi == key_lo) begin
      f = 0;
    end else if (ip > key_hi) begin
      f = 65536;
    end else begin
      num = (longint'(pos) - (longint'(key_lo) << kei_pkg::POS_FRAC_BITS)) << 16;
      den = (longint'(key_hi) - longint'(key_lo)) << kei_pkg::POS_FRAC_BITS;
      f   = num / den;
      if (f > 65536) f = 65536;
      case (curve)
        kei_pkg::CURVE_IN_OUT:   f = (65536 - signed_cos(2 * f)) >>> 1;
        kei_pkg::CURVE_EASE_IN:  f = 65536 - signed_cos(f);
        kei_pkg::CURVE_EASE_OUT: f = -signed_cos(f + 65536);
        default: ;
      endcase
    end
    p.frac = kei_pkg::FRAC_W'(f);
    p.x    = kei_pkg::COORD_W'(mix(sx, ex, f));
    p.y    = kei_pkg::COORD_W'(mix(sy, ey, f));
    return p;
  endfunction

  initial begin
    for (int k = 0; k <= NCOS; k++) begin
      cos_lut[k] = cos_q16((HALF_PI * k + NCOS / 2) / NCOS);
    end
  end

  assign pending_o = expected_points.size();

  always @(posedge clk_i or negedge rst_ni) begin
    point_t want;
    int     errs;
    errs = 0;
    if (!rst_ni) begin
      key_lo <= '0; key_hi <= '0; curve <= kei_pkg::CURVE_LINEAR;
      sx <= '0; sy <= '0; ex <= '0; ey <= '0;
      fail_count_o <= 0;
      expected_points.delete();
    end else begin
      if (pos_ch.valid && pos_ch.ready) begin
        expected_points.push_back(eval_position(pos_ch.timeline_pos));
      end
      if (res_ch.valid && res_ch.ready) begin
        if (expected_points.size() == 0) begin
          $error("unexpected result frac=%0d", res_ch.eased_fraction);
          errs++;
        end else begin
          want = expected_points.pop_front();
          if (res_ch.eased_fraction !== want.frac) begin
            $error("eased_fraction exp %0d got %0d", want.frac, res_ch.eased_fraction);
            errs++;
          end
          if (res_ch.blend_x !== want.x) begin
            $error("blend_x exp %0d got %0d", want.x, res_ch.blend_x);
            errs++;
          end
          if (res_ch.blend_y !== want.y) begin
            $error("blend_y exp %0d got %0d", want.y, res_ch.blend_y);
            errs++;
          end
        end
      end
      fail_count_o <= fail_count_o + errs;
      if (cfg_we_i) begin
        case (kei_pkg::cfg_idx_e'(cfg_idx_i))
          kei_pkg::CFG_SPAN_BEGIN: key_lo <= cfg_data_i;
          kei_pkg::CFG_SPAN_END:   key_hi <= cfg_data_i;
          kei_pkg::CFG_CURVE_MODE: curve  <= kei_pkg::curve_e'(cfg_data_i[1:0]);
          kei_pkg::CFG_START_X:    sx     <= cfg_data_i;
          kei_pkg::CFG_START_Y:    sy     <= cfg_data_i;
          kei_pkg::CFG_FINISH_X:   ex     <= cfg_data_i;
          kei_pkg::CFG_FINISH_Y:   ey     <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end
endmodule

`default_nettype wire

>>> verif/keyframe_eased_interpolator_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// keyframe_eased_interpolator_test
// Drives positions through several span, curve and endpoint settings with
// bursty requests and a stalling result side; the checker scores results.
// ---------------------------------------------------------------------------
`default_nettype none

module keyframe_eased_interpolator_test;

  localparam int LATENCY = 14;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [kei_pkg::CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [kei_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;
  int fail_count, pending;
  int hold_off = 0;
  logic [15:0] cur_lo, cur_hi;

  logic [kei_pkg::POS_W-1:0] send_list [9] = '{
    {16'd9, 8'hFF}, {16'd10, 8'd0}, {16'd10, 8'd1}, {16'd15, 8'h80}, {16'd19, 8'hFF},
    {16'd20, 8'd0}, {16'd20, 8'hFF}, {16'd21, 8'd0}, {16'd14, 8'h33}
  };

  kei_in_if  pos_ch ();
  kei_out_if res_ch ();

  keyframe_eased_interpolator u_top (
    .clk_i, .rst_ni, .in_i(pos_ch), .out_o(res_ch), .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  keyframe_eased_interpolator_checker u_checker (
    .clk_i, .rst_ni, .pos_ch, .res_ch, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    pos_ch.valid = 1'b0;
    pos_ch.timeline_pos = '0;
    res_ch.ready = 1'b0;
  end

  // Result side: own stall pattern, plus a long hold-off on request.
  initial begin
    int mode;
    forever begin
      @(negedge clk_i);
      mode = $urandom_range(0, 99);
      if (hold_off > 0) begin
        res_ch.ready <= 1'b0;
        hold_off = hold_off - 1;
      end else begin
        res_ch.ready <= (mode < 70);
      end
    end
  end

  task automatic write_reg(kei_pkg::cfg_idx_e idx, logic [15:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    if (idx == kei_pkg::CFG_SPAN_BEGIN) cur_lo = data;
    if (idx == kei_pkg::CFG_SPAN_END) cur_hi = data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk_i);
    repeat (LATENCY + 2) @(negedge clk_i);
  endtask

  task automatic set_span(logic [15:0] lo, logic [15:0] hi, kei_pkg::curve_e c);
    drain();
    write_reg(kei_pkg::CFG_SPAN_BEGIN, lo);
    write_reg(kei_pkg::CFG_SPAN_END, hi);
    write_reg(kei_pkg::CFG_CURVE_MODE, 16'(c));
    write_reg(kei_pkg::CFG_START_X, 16'($urandom));
    write_reg(kei_pkg::CFG_START_Y, 16'($urandom));
    write_reg(kei_pkg::CFG_FINISH_X, 16'($urandom));
    write_reg(kei_pkg::CFG_FINISH_Y, 16'($urandom));
  endtask

  // Send one request, holding valid across back-to-back items.
  task automatic send_pos(logic [kei_pkg::POS_W-1:0] pos, bit keep);
    pos_ch.valid        <= 1'b1;
    pos_ch.timeline_pos <= pos;
    @(posedge clk_i);
    while (!pos_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    if (!keep) begin
      pos_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
  endtask

  function automatic logic [kei_pkg::POS_W-1:0] near_span();
    int sel;
    logic [15:0] key;
    sel = $urandom_range(0, 9);
    if (sel == 0) return kei_pkg::POS_W'($urandom);
    key = (sel < 8) ? 16'(cur_lo + $urandom_range(0, int'(cur_hi - cur_lo) + 1))
                    : 16'(cur_lo - 1 + $urandom_range(0, 2));
    return {key, 8'($urandom)};
  endfunction

  task automatic run_bursts(int count);
    int burst;
    while (count > 0) begin
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst && count > 0; b++) begin
        count--;
        send_pos(near_span(), b + 1 < burst && count > 0);
      end
      if ($urandom_range(0, 3) != 0) repeat ($urandom_range(0, 5)) @(negedge clk_i);
    end
  endtask

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    // Directed: field extremes, empty span, inverted span, last-key clamp.
    set_span(16'd0, 16'd0, kei_pkg::CURVE_LINEAR);
    send_pos(24'd0, 1'b0);
    send_pos(24'hFFFFFF, 1'b0);
    set_span(16'd10, 16'd20, kei_pkg::CURVE_LINEAR);
    write_reg(kei_pkg::CFG_START_X, 16'h8000);
    write_reg(kei_pkg::CFG_FINISH_X, 16'h7FFF);
    write_reg(kei_pkg::CFG_START_Y, 16'h7FFF);
    write_reg(kei_pkg::CFG_FINISH_Y, 16'h8000);
    foreach (send_list[i]) send_pos(send_list[i], 1'b1);
    pos_ch.valid <= 1'b0;
    for (int c = 1; c < 4; c++) begin
      set_span(16'd10, 16'd20, kei_pkg::curve_e'(c));
      send_pos({16'd10, 8'd0}, 1'b1);
      send_pos({16'd15, 8'd0}, 1'b1);
      send_pos({16'd20, 8'hFF}, 1'b0);
    end
    set_span(16'd30, 16'd5, kei_pkg::CURVE_IN_OUT);
    send_pos({16'd29, 8'hFF}, 1'b1);
    send_pos({16'd30, 8'd0}, 1'b0);
    set_span(16'd0, 16'hFFFF, kei_pkg::CURVE_EASE_OUT);
    send_pos(24'hFFFFFF, 1'b1);
    send_pos(24'h7FFFFF, 1'b1);
    send_pos(24'h000001, 1'b0);

    // Long result stall while requests keep coming; then a pause to drain.
    set_span(16'd100, 16'd107, kei_pkg::CURVE_LINEAR);
    hold_off = 200;
    run_bursts(60);
    while (pending != 0) @(negedge clk_i);

    for (int ph = 0; ph < 14; ph++) begin
      logic [15:0] lo;
      lo = 16'($urandom);
      case (ph % 4)
        0: set_span(lo, 16'(lo + $urandom_range(1, 3)),
                    kei_pkg::curve_e'($urandom_range(0, 3)));
        1: set_span(lo, 16'(lo + $urandom_range(1, 400)),
                    kei_pkg::curve_e'($urandom_range(0, 3)));
        2: set_span(16'(lo & 16'h00FF), 16'hFFFF, kei_pkg::curve_e'($urandom_range(0, 3)));
        default: set_span(lo, 16'(lo - $urandom_range(0, 50)), kei_pkg::curve_e'(ph & 3));
      endcase
      run_bursts(60);
    end

    drain();
    if (fail_count == 0) begin
      $display("keyframe_eased_interpolator_test: clean");
    end else begin
      $display("keyframe_eased_interpolator_test: errors");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("keyframe_eased_interpolator_test: errors");
    $finish;
  end
endmodule

`default_nettype wire
